// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Consequent must hold on the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== src/dttf_pkg.sv =====
// ----------------------------------------------------------------------------
// dttf_pkg
// Shared constants, types and the power-of-ten table for the text parser.
// ----------------------------------------------------------------------------
package dttf_pkg;

    // parameter defaults
    localparam int FRAC_BITS_DEF  = 16;
    localparam int MAX_DIGITS_DEF = 19;
    localparam int VALUE_BITS_DEF = 48;

    localparam int CHAR_W = 8;
    localparam int MANT_W = 64;
    localparam int CNT_W  = 5;
    localparam int ERR_W  = 2;
    localparam int PH_W   = 3;

    // parse phases
    localparam logic [PH_W-1:0] PH_LEAD  = 3'd0;
    localparam logic [PH_W-1:0] PH_SIGN  = 3'd1;
    localparam logic [PH_W-1:0] PH_INT   = 3'd2;
    localparam logic [PH_W-1:0] PH_FRAC  = 3'd3;
    localparam logic [PH_W-1:0] PH_TRAIL = 3'd4;
    localparam logic [PH_W-1:0] PH_ERR   = 3'd5;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BLANK = 2'd1;
    localparam logic [ERR_W-1:0] ERR_CHAR  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_OVF   = 2'd3;

    // character codes
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'd46;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;

    // parser state after the current character
    typedef struct packed {
        logic              neg;
        logic [MANT_W-1:0] mant;
        logic [CNT_W-1:0]  cnt;
        logic              point;
        logic [PH_W-1:0]   phase;
        logic [ERR_W-1:0]  sticky;
    } scan_info_t;

    function automatic logic [MANT_W-1:0] pow_ten(input logic [CNT_W-1:0] k);
        logic [MANT_W-1:0] p;
        case (k)
            5'd0:    p = 64'd1;
            5'd1:    p = 64'd10;
            5'd2:    p = 64'd100;
            5'd3:    p = 64'd1000;
            5'd4:    p = 64'd10000;
            5'd5:    p = 64'd100000;
            5'd6:    p = 64'd1000000;
            5'd7:    p = 64'd10000000;
            5'd8:    p = 64'd100000000;
            5'd9:    p = 64'd1000000000;
            5'd10:   p = 64'd10000000000;
            5'd11:   p = 64'd100000000000;
            5'd12:   p = 64'd1000000000000;
            5'd13:   p = 64'd10000000000000;
            5'd14:   p = 64'd100000000000000;
            5'd15:   p = 64'd1000000000000000;
            5'd16:   p = 64'd10000000000000000;
            5'd17:   p = 64'd100000000000000000;
            5'd18:   p = 64'd1000000000000000000;
            5'd19:   p = 64'd10000000000000000000;
            default: p = 64'd1;
        endcase
        return p;
    endfunction

endpackage

// ===== src/decimal_text_to_fixed_point.sv =====
// Timing: the result is registered once the sequencer is in its convert state, the divider
//   is idle and the output slot is free; the divider runs only when fraction digits are present.
// Throughput: one character per cycle while ready is high; after each flagged last character
//   input ready stays low until the result has been loaded into the output register.
// Reset: aresetn synchronous, active low; clears parser phase, sequencer and output valid.
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point
// Parses a decimal text number (one byte per transfer, tlast on the final
// character) into a saturated two's-complement fixed-point value with status.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module decimal_text_to_fixed_point #(
    parameter int FRAC_BITS  = dttf_pkg::FRAC_BITS_DEF,
    parameter int MAX_DIGITS = dttf_pkg::MAX_DIGITS_DEF,
    parameter int VALUE_BITS = dttf_pkg::VALUE_BITS_DEF,
    localparam int OUT_W     = ((3 + VALUE_BITS + 7) / 8) * 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input character stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [dttf_pkg::CHAR_W-1:0] s_axis_tdata,   // [7:0] char_code
    input  logic                        s_axis_tlast,   // last_char
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [OUT_W-1:0]            m_axis_tdata    // [0] ok, [2:1] error_code,
                                                        // [VALUE_BITS+2:3] fixed_value
);

    // Dividend width: mantissa shifted left by the fraction bits.
    localparam int W = dttf_pkg::MANT_W + FRAC_BITS;
    // The 0.5 rounding term, scaled; zero when there are no fraction bits.
    localparam logic [W-1:0] HALF = (W'(1) << FRAC_BITS) >> 1;
    localparam logic [W-1:0] LIM_POS = (W'(1) << (VALUE_BITS - 1)) - W'(1);
    localparam logic [W-1:0] LIM_NEG = W'(1) << (VALUE_BITS - 1);
    localparam logic [VALUE_BITS-1:0] SAT_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] SAT_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // sequencer states
    localparam logic ST_SCAN = 1'b0;   // taking characters
    localparam logic ST_CONV = 1'b1;   // divider running / result waiting to load

    logic                         state_reg, state_next;
    logic                         job_neg_reg;
    logic [dttf_pkg::ERR_W-1:0]   job_err_reg;
    logic                         m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]             m_data_reg;

    dttf_pkg::scan_info_t         info_next;
    logic                         in_xfer;
    logic                         last_xfer;
    logic [dttf_pkg::ERR_W-1:0]   pre_err;
    logic                         div_start;
    logic [W-1:0]                 dividend;
    logic [dttf_pkg::MANT_W-1:0]  divisor;
    logic                         div_busy;
    logic [W-1:0]                 quotient;

    logic                         load;
    logic                         ovf;
    logic [dttf_pkg::ERR_W-1:0]   res_err;
    logic [VALUE_BITS-1:0]        res_val;

    // assertion helpers
    logic [dttf_pkg::ERR_W-1:0]   m_code;
    logic                         chk_idle_in;
    logic                         chk_ok_code;
    logic                         chk_text_zero;

    assign s_axis_tready = (state_reg == ST_SCAN);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign last_xfer     = in_xfer && s_axis_tlast;

    dttf_scan #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .char_acc  (in_xfer),
        .char_last (s_axis_tlast),
        .char_code (s_axis_tdata),
        .info_next (info_next)
    );

    // Classify the string once its last character is in.
    always_comb begin
        case (info_next.phase)
            dttf_pkg::PH_LEAD, dttf_pkg::PH_SIGN: pre_err = dttf_pkg::ERR_BLANK;
            dttf_pkg::PH_ERR:                     pre_err = info_next.sticky;
            default:                              pre_err = dttf_pkg::ERR_NONE;
        endcase
    end

    // magnitude = floor((mant * 2^FRAC_BITS + half) / 10^digits); the low
    // bits of the shifted mantissa are zero, so the half term (added only after a point) is an OR.
    assign dividend  = (W'(info_next.mant) << FRAC_BITS) | (info_next.point ? HALF : '0);
    assign divisor   = dttf_pkg::pow_ten(info_next.point ? info_next.cnt : '0);
    assign div_start = last_xfer && (pre_err == dttf_pkg::ERR_NONE);

    dttf_div #(
        .W (W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // Range check and sign application on the quotient.
    assign ovf = job_neg_reg ? (quotient > LIM_NEG) : (quotient > LIM_POS);

    always_comb begin
        case (job_err_reg)
            dttf_pkg::ERR_NONE: begin
                if (ovf) begin
                    res_err = dttf_pkg::ERR_OVF;
                    res_val = job_neg_reg ? SAT_NEG : SAT_POS;
                end else begin
                    res_err = dttf_pkg::ERR_NONE;
                    res_val = job_neg_reg ? (VALUE_BITS'(0) - quotient[VALUE_BITS-1:0])
                                          : quotient[VALUE_BITS-1:0];
                end
            end
            dttf_pkg::ERR_OVF: begin
                res_err = dttf_pkg::ERR_OVF;
                res_val = job_neg_reg ? SAT_NEG : SAT_POS;
            end
            default: begin
                res_err = job_err_reg;
                res_val = '0;
            end
        endcase
    end

    // Load the output register once the divider is idle and the slot is free.
    assign load = (state_reg == ST_CONV) && !div_busy && (!m_valid_reg || m_axis_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_SCAN: if (last_xfer) state_next = ST_CONV;
            ST_CONV: if (load)      state_next = ST_SCAN;
            default: state_next = ST_SCAN;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_SCAN;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (last_xfer) begin
            job_neg_reg <= info_next.neg;
            job_err_reg <= pre_err;
        end
        if (load) begin
            m_data_reg <= OUT_W'({res_val, res_err, res_err == dttf_pkg::ERR_NONE});
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    assign m_code        = m_axis_tdata[2:1];
    assign chk_idle_in   = !(div_busy && s_axis_tready);
    assign chk_ok_code   = !m_axis_tvalid || (m_axis_tdata[0] == (m_code == dttf_pkg::ERR_NONE));
    assign chk_text_zero = !m_axis_tvalid ||
                           !(m_code == dttf_pkg::ERR_BLANK || m_code == dttf_pkg::ERR_CHAR) ||
                           (m_axis_tdata[VALUE_BITS+2:3] == '0);

    `ASSERT_ALWAYS(a_no_input_while_div, aclk, aresetn, chk_idle_in, "ready while dividing")
    `ASSERT_NEXT(a_pause_after_last, aclk, aresetn, last_xfer, !s_axis_tready, "ready after tlast")
    `ASSERT_ALWAYS(a_ok_matches_code, aclk, aresetn, chk_ok_code, "ok flag vs error code")
    `ASSERT_ALWAYS(a_text_err_zero, aclk, aresetn, chk_text_zero, "nonzero value on text error")

endmodule

// ===== src/dttf_scan.sv =====
// ----------------------------------------------------------------------------
// dttf_scan
// Per-character parser: phase tracking and decimal mantissa accumulation.
// ----------------------------------------------------------------------------
module dttf_scan #(
    parameter int MAX_DIGITS = dttf_pkg::MAX_DIGITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             char_acc,
    input  logic                             char_last,
    input  logic [dttf_pkg::CHAR_W-1:0]      char_code,
    output dttf_pkg::scan_info_t             info_next
);

    localparam int ACC_W = dttf_pkg::MANT_W + 4;
    localparam logic [ACC_W-1:0] BOUND =
        ACC_W'(dttf_pkg::pow_ten(dttf_pkg::CNT_W'(MAX_DIGITS))) - ACC_W'(1);
    localparam logic [dttf_pkg::CNT_W-1:0] CNT_MAX = dttf_pkg::CNT_W'(MAX_DIGITS);
    // idle parser: leading-space phase, everything else cleared
    localparam dttf_pkg::scan_info_t INFO_RST = '{
        neg:    1'b0,
        mant:   '0,
        cnt:    '0,
        point:  1'b0,
        phase:  dttf_pkg::PH_LEAD,
        sticky: dttf_pkg::ERR_NONE
    };

    dttf_pkg::scan_info_t info_reg;

    logic             is_space;
    logic             is_digit;
    logic [3:0]       digit;
    logic [ACC_W-1:0] mac;
    logic             fits;

    assign is_space = (char_code == dttf_pkg::CH_SPACE) ||
                      (char_code >= dttf_pkg::CH_TAB && char_code <= dttf_pkg::CH_CR);
    assign is_digit = (char_code >= dttf_pkg::CH_ZERO) && (char_code <= dttf_pkg::CH_NINE);
    assign digit    = char_code[3:0];
    // mant * 10 + d
    assign mac  = {info_reg.mant, 3'b000} + {2'b00, info_reg.mant, 1'b0} + ACC_W'(digit);
    assign fits = (mac <= BOUND);

    always_comb begin
        info_next = info_reg;
        case (info_reg.phase)
            dttf_pkg::PH_LEAD, dttf_pkg::PH_SIGN: begin
                if (info_reg.phase == dttf_pkg::PH_LEAD && is_space) begin
                    info_next.phase = dttf_pkg::PH_LEAD;
                end else if (info_reg.phase == dttf_pkg::PH_LEAD &&
                             char_code == dttf_pkg::CH_MINUS) begin
                    info_next.neg   = 1'b1;
                    info_next.phase = dttf_pkg::PH_SIGN;
                end else if (is_digit) begin
                    info_next.mant  = dttf_pkg::MANT_W'(digit);
                    info_next.phase = dttf_pkg::PH_INT;
                end else begin
                    info_next.sticky = dttf_pkg::ERR_CHAR;
                    info_next.phase  = dttf_pkg::PH_ERR;
                end
            end
            dttf_pkg::PH_INT: begin
                if (is_digit) begin
                    if (fits) begin
                        info_next.mant = mac[dttf_pkg::MANT_W-1:0];
                    end else begin
                        info_next.sticky = dttf_pkg::ERR_OVF;
                        info_next.phase  = dttf_pkg::PH_ERR;
                    end
                end else if (char_code == dttf_pkg::CH_POINT) begin
                    info_next.point = 1'b1;
                    info_next.phase = dttf_pkg::PH_FRAC;
                end else if (is_space) begin
                    info_next.phase = dttf_pkg::PH_TRAIL;
                end else begin
                    info_next.sticky = dttf_pkg::ERR_CHAR;
                    info_next.phase  = dttf_pkg::PH_ERR;
                end
            end
            dttf_pkg::PH_FRAC: begin
                if (is_digit) begin
                    // excess fraction digits are dropped
                    if (info_reg.cnt < CNT_MAX && fits) begin
                        info_next.mant = mac[dttf_pkg::MANT_W-1:0];
                        info_next.cnt  = info_reg.cnt + 1'b1;
                    end
                end else if (is_space) begin
                    info_next.phase = dttf_pkg::PH_TRAIL;
                end else begin
                    info_next.sticky = dttf_pkg::ERR_CHAR;
                    info_next.phase  = dttf_pkg::PH_ERR;
                end
            end
            dttf_pkg::PH_TRAIL: begin
                if (!is_space) begin
                    info_next.sticky = dttf_pkg::ERR_CHAR;
                    info_next.phase  = dttf_pkg::PH_ERR;
                end
            end
            default: begin
                info_next = info_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            info_reg <= INFO_RST;
        end else if (char_acc) begin
            if (char_last) begin
                info_reg <= INFO_RST;
            end else begin
                info_reg <= info_next;
            end
        end
    end

endmodule

// ===== src/dttf_div.sv =====
// ----------------------------------------------------------------------------
// dttf_div
// Restoring divider, one quotient bit per cycle; divide-by-one bypass.
// ----------------------------------------------------------------------------
module dttf_div #(
    parameter int W = dttf_pkg::MANT_W + dttf_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [W-1:0]                dividend,
    input  logic [dttf_pkg::MANT_W-1:0] divisor,
    output logic                        busy,
    output logic [W-1:0]                quotient
);

    localparam int CW = $clog2(W + 1);
    localparam int DW = dttf_pkg::MANT_W;

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dvs_reg;
    logic [W-1:0]  quo_reg;

    logic [DW:0]   rsh;
    logic          ge;
    logic [DW:0]   diff;

    assign rsh  = {rem_reg, quo_reg[W-1]};
    assign ge   = (rsh >= {1'b0, dvs_reg});
    assign diff = rsh - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= (divisor != DW'(1));
            cnt_reg  <= CW'(W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[W-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : rsh[DW-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule
